>>> hdl/sha1h_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants of the SHA-1 stream hasher: controller states,
// byte source codes, command and status groups, round and initial constants.
// ----------------------------------------------------------------------------
package sha1h_pkg;

    localparam int unsigned ROUNDS       = 80;
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned ROUND_W      = $clog2(ROUNDS);
    localparam int unsigned IDX_W        = $clog2(DIGEST_WORDS);

    localparam logic [7:0] MARK_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift;
        byte_sel_t sel;
        logic      start;
        logic      round;
        logic      fold;
        logic      out_adv;
        logic      clear;
    } cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_len;
        logic round_last;
        logic word_last;
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/sha1h_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h channel interfaces
// Valid/ready channels for message items and for digest words.
// ----------------------------------------------------------------------------
interface sha1h_msg_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface sha1h_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface
`default_nettype wire

>>> hdl/sha1h_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_ctrl
// Sequencer: absorbs bytes, walks the padding, runs compressions and
// hands out the digest words.
// ----------------------------------------------------------------------------
module sha1h_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           msg_valid,
    input  wire logic           func,
    output logic                msg_ready,
    output logic                digest_valid,
    input  wire logic           digest_ready,
    input  wire sha1h_pkg::sts_t sts,
    output sha1h_pkg::cmd_t     cmd
);

    sha1h_pkg::state_t state_reg;
    sha1h_pkg::state_t state_next;
    logic              fin_reg;
    logic              fin_next;
    logic              tail_reg;
    logic              tail_next;
    logic              msg_xfer;
    logic              digest_xfer;

    assign msg_xfer    = msg_valid && (state_reg == sha1h_pkg::S_IDLE);
    assign digest_xfer = digest_ready && (state_reg == sha1h_pkg::S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1h_pkg::S_IDLE;
            fin_reg   <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            tail_reg  <= tail_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        tail_next  = tail_reg;
        case (state_reg)
            sha1h_pkg::S_IDLE:
            begin
                if (msg_xfer)
                begin
                    fin_next = func;
                    if (sts.fill_full)
                        state_next = sha1h_pkg::S_ROUND;
                    else if (func)
                        state_next = sha1h_pkg::S_PAD;
                end
            end
            sha1h_pkg::S_PAD:
            begin
                if (sts.fill_len)
                    state_next = sha1h_pkg::S_LEN;
                else if (sts.fill_full)
                    state_next = sha1h_pkg::S_ROUND;
            end
            sha1h_pkg::S_LEN:
            begin
                if (sts.fill_full)
                begin
                    tail_next  = 1'b1;
                    state_next = sha1h_pkg::S_ROUND;
                end
            end
            sha1h_pkg::S_ROUND:
            begin
                if (sts.round_last)
                    state_next = sha1h_pkg::S_FOLD;
            end
            sha1h_pkg::S_FOLD:
            begin
                if (tail_reg)
                    state_next = sha1h_pkg::S_OUT;
                else if (fin_reg)
                    state_next = sha1h_pkg::S_PAD;
                else
                    state_next = sha1h_pkg::S_IDLE;
            end
            sha1h_pkg::S_OUT:
            begin
                if (digest_xfer && sts.word_last)
                begin
                    fin_next   = 1'b0;
                    tail_next  = 1'b0;
                    state_next = sha1h_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sha1h_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = sha1h_pkg::SEL_DATA;
        msg_ready    = 1'b0;
        digest_valid = 1'b0;
        case (state_reg)
            sha1h_pkg::S_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_xfer)
                begin
                    cmd.shift = 1'b1;
                    cmd.sel   = func ? sha1h_pkg::SEL_MARK : sha1h_pkg::SEL_DATA;
                    cmd.start = sts.fill_full;
                end
            end
            sha1h_pkg::S_PAD:
            begin
                if (!sts.fill_len)
                begin
                    cmd.shift = 1'b1;
                    cmd.sel   = sha1h_pkg::SEL_ZERO;
                    cmd.start = sts.fill_full;
                end
            end
            sha1h_pkg::S_LEN:
            begin
                cmd.shift = 1'b1;
                cmd.sel   = sha1h_pkg::SEL_LEN;
                cmd.start = sts.fill_full;
            end
            sha1h_pkg::S_ROUND:
            begin
                cmd.round = 1'b1;
            end
            sha1h_pkg::S_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            sha1h_pkg::S_OUT:
            begin
                digest_valid = 1'b1;
                cmd.out_adv  = digest_xfer;
                cmd.clear    = digest_xfer && sts.word_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/sha1h_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1h_datapath
// Block window, message schedule, round unit, chaining words, length
// counter and digest word select.
// ----------------------------------------------------------------------------
module sha1h_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sha1h_pkg::cmd_t cmd,
    input  wire logic [7:0]      data_byte,
    output sha1h_pkg::sts_t      sts,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index,
    output logic                 last_word
);

    // 64-byte window: bytes shift in at the low end, word 0 sits at the top
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [sha1h_pkg::ROUND_W-1:0] round_reg;
    logic [sha1h_pkg::IDX_W-1:0]   idx_reg;
    logic [31:0]  h_reg [sha1h_pkg::DIGEST_WORDS];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [7:0]   shift_byte;
    logic [7:0]   len_byte;
    logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]  f_val, k_val, t_val;

    assign w0    = win_reg[511:480];
    assign w2    = win_reg[447:416];
    assign w8    = win_reg[255:224];
    assign w13   = win_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // length bytes go out most significant first while fill runs 56..63
    assign len_byte = 8'(len_reg >> {~fill_reg[2:0], 3'b000});

    always_comb
    begin
        case (cmd.sel)
            sha1h_pkg::SEL_DATA: shift_byte = data_byte;
            sha1h_pkg::SEL_MARK: shift_byte = sha1h_pkg::MARK_BYTE;
            sha1h_pkg::SEL_ZERO: shift_byte = 8'h00;
            sha1h_pkg::SEL_LEN:  shift_byte = len_byte;
            default:             shift_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        if (round_reg < sha1h_pkg::ROUND_W'(20))
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1h_pkg::K_0;
        end
        else if (round_reg < sha1h_pkg::ROUND_W'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1h_pkg::K_1;
        end
        else if (round_reg < sha1h_pkg::ROUND_W'(60))
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1h_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1h_pkg::K_3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    always_comb
    begin
        win_next = win_reg;
        if (cmd.shift)
            win_next = {win_reg[503:0], shift_byte};
        else if (cmd.round)
            win_next = {win_reg[479:0], w_new};
    end

    // window and working variables carry no reset
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (cmd.start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < sha1h_pkg::DIGEST_WORDS; i++)
                h_reg[i] <= sha1h_pkg::H_INIT[i];
        end
        else
        begin
            if (cmd.shift)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.shift && (cmd.sel == sha1h_pkg::SEL_DATA))
                len_reg <= len_reg + 64'd8;
            if (cmd.start)
                round_reg <= '0;
            else if (cmd.round)
                round_reg <= round_reg + sha1h_pkg::ROUND_W'(1);
            if (cmd.fold)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (cmd.clear)
            begin
                len_reg <= '0;
                idx_reg <= '0;
                for (int i = 0; i < sha1h_pkg::DIGEST_WORDS; i++)
                    h_reg[i] <= sha1h_pkg::H_INIT[i];
            end
            else if (cmd.out_adv)
                idx_reg <= idx_reg + sha1h_pkg::IDX_W'(1);
        end
    end

    assign sts.fill_full  = (fill_reg == 6'd63);
    assign sts.fill_len   = (fill_reg == 6'd56);
    assign sts.round_last = (round_reg == sha1h_pkg::ROUND_W'(sha1h_pkg::ROUNDS - 1));
    assign sts.word_last  = (idx_reg == sha1h_pkg::IDX_W'(sha1h_pkg::DIGEST_WORDS - 1));

    assign digest_word = h_reg[idx_reg];
    assign word_index  = 3'(idx_reg);
    assign last_word   = sts.word_last;

endmodule
`default_nettype wire

>>> hdl/sha1_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream with padding, length append and digest output.
// ----------------------------------------------------------------------------
// A message byte (func 0) is taken while idle. The transfer that completes
// a 64-byte block starts a compression: 80 rounds at one round a cycle on a
// single round unit, then a fold into the chaining words, so msg ready stays
// low after every 64th byte until the fold is done. A finish (func 0x1)
// shifts in the 0x80 byte, then one padding or length byte per cycle, save
// during a compression, up to the end of the block, with no byte shifted
// where the zero padding meets the length field, and one more compression
// when the marker leaves fewer than eight bytes; the five digest words then
// leave one per transfer, word 0 first, last_word on word 4, and the block
// returns to its initial state. No input is taken while padding,
// compressing or presenting the digest.
module sha1_stream_hasher (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sha1h_msg_if.sink      msg,
    sha1h_digest_if.source digest
);

    sha1h_pkg::cmd_t cmd;
    sha1h_pkg::sts_t sts;

    sha1h_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg.valid),
        .func         (msg.func),
        .msg_ready    (msg.ready),
        .digest_valid (digest.valid),
        .digest_ready (digest.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    sha1h_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (msg.data_byte),
        .sts         (sts),
        .digest_word (digest.digest_word),
        .word_index  (digest.word_index),
        .last_word   (digest.last_word)
    );

`ifndef SYNTH
    // input and output sides never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> !msg.ready)
        else $error("msg ready while digest is presented");

    // words advance by one per transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && !digest.last_word) |=>
        (digest.valid && (digest.word_index == $past(digest.word_index) + 3'd1)))
        else $error("digest word order broken");

    // the last word ends the digest and reopens the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last_word) |=>
        (!digest.valid && msg.ready && (digest.word_index == 3'd0)))
        else $error("digest did not close after last word");

    // a finish always pads before anything is presented
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && msg.func) |=> (!digest.valid && !msg.ready))
        else $error("finish not followed by padding");
`endif

endmodule
`default_nettype wire

>>> tb/sha1_stream_hasher_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Feeds byte messages and finish commands into the SHA-1 stream hasher and
// checks every digest word against a known digest or a behavioural SHA-1
// model kept alongside. A short scripted run with known digests comes first,
// then random messages, the first 120 bytes long and the rest up to 12 bytes,
// under changing handshake pressure on both channels.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int RAND_ITEMS  = 155;
    localparam int MIN_DIGESTS = 4;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    typedef struct {
        logic         func;
        logic [7:0]   data;
        bit           typed;
        logic [159:0] digest;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    sha1h_msg_if    msg_ch ();
    sha1h_digest_if dig_ch ();

    sha1_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // SHA-1 model state
    logic [31:0] chain_h [sha1h_pkg::DIGEST_WORDS];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] bit_len;
    logic [31:0] model_digest [sha1h_pkg::DIGEST_WORDS];

    digest_beat_t pending_words [$];
    int           errors;
    int           stall_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           rand_items;
    int           msg_no;

    stim_row_t script [13] = '{
        '{1'b1, 8'h00, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{1'b1, 8'hFF, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{1'b0, 8'h61, 1'b0, '0},
        '{1'b0, 8'h62, 1'b0, '0},
        '{1'b0, 8'h63, 1'b0, '0},
        '{1'b1, 8'h5A, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 8'h80, 1'b0, '0},
        '{1'b1, 8'h00, 1'b0, '0},
        '{1'b0, 8'h55, 1'b0, '0},
        '{1'b0, 8'hAA, 1'b0, '0},
        '{1'b1, 8'hC3, 1'b0, '0}
    };

    function automatic void model_reset();
        int i;
        for (i = 0; i < sha1h_pkg::DIGEST_WORDS; i++)
            chain_h[i] = sha1h_pkg::H_INIT[i];
        fill    = 0;
        bit_len = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (r = 16; r < 80; r++)
        begin
            x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2];
        d = chain_h[3]; e = chain_h[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1h_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1h_pkg::K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1h_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1h_pkg::K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
        chain_h[3] += d; chain_h[4] += e;
    endfunction

    // Returns 1 when the item finished a message and model_digest holds its digest.
    function automatic bit model_item(input logic f, input logic [7:0] b);
        int i;
        if (!f)
        begin
            blk[fill] = b;
            fill++;
            bit_len += 64'd8;
            if (fill == 64)
            begin
                sha1_compress();
                fill = 0;
            end
            return 1'b0;
        end
        blk[fill] = sha1h_pkg::MARK_BYTE;
        fill++;
        // marker leaves no room for the length: spill into an extra block
        if (fill > 56)
        begin
            while (fill < 64)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            sha1_compress();
            fill = 0;
        end
        while (fill < 56)
        begin
            blk[fill] = 8'h00;
            fill++;
        end
        for (i = 0; i < 8; i++)
            blk[56+i] = bit_len[63-8*i -: 8];
        sha1_compress();
        for (i = 0; i < sha1h_pkg::DIGEST_WORDS; i++)
            model_digest[i] = chain_h[i];
        model_reset();
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic f, input logic [7:0] b,
                             input bit typed, input logic [159:0] typed_words);
        digest_beat_t beat;
        int i;
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_ch.valid = 1'b0;
            @(negedge clk);
        end
        msg_ch.valid     = 1'b1;
        msg_ch.func      = f;
        msg_ch.data_byte = b;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        if (model_item(f, b))
        begin
            for (i = 0; i < sha1h_pkg::DIGEST_WORDS; i++)
            begin
                beat.word = typed ? typed_words[159-32*i -: 32] : model_digest[i];
                beat.idx  = i[2:0];
                beat.last = (i == sha1h_pkg::DIGEST_WORDS - 1);
                pending_words.push_back(beat);
            end
        end
        @(negedge clk);
    endtask

    // Hold the sender off until every digest word owed has been taken.
    task automatic drain_digests();
        msg_ch.valid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("%s mismatch: expected %h, got %h", what, want, got);
    endtask

    always @(negedge clk)
        dig_ch.ready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digest word %h index %0d",
                             dig_ch.digest_word, dig_ch.word_index);
            end
            else
            begin
                digest_beat_t want;
                want = pending_words.pop_front();
                if (dig_ch.digest_word !== want.word)
                    note_mismatch("digest_word", want.word, dig_ch.digest_word);
                if (dig_ch.word_index !== want.idx)
                    note_mismatch("word_index", want.idx, dig_ch.word_index);
                if (dig_ch.last_word !== want.last)
                    note_mismatch("last_word", want.last, dig_ch.last_word);
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        int len;
        rst_n            = 1'b0;
        msg_ch.valid     = 1'b0;
        msg_ch.func      = 1'b0;
        msg_ch.data_byte = 8'h00;
        dig_ch.ready     = 1'b0;
        errors           = 0;
        stall_cycles     = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        rand_items       = 0;
        model_reset();
        for (i = 0; i < 64; i++)
            blk[i] = 8'h00;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < $size(script); i++)
            send_item(script[i].func, script[i].data, script[i].typed, script[i].digest);
        drain_digests();

        // Random messages; open with a full block followed by a tail that
        // forces the padding to spill into an extra block.
        for (msg_no = 0; rand_items < RAND_ITEMS || msg_no < MIN_DIGESTS; msg_no++)
        begin
            case (msg_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (msg_no)
                0: len = 120;
                default: len = $urandom_range(12);
            endcase
            for (i = 0; i < len; i++)
            begin
                send_item(1'b0, 8'($urandom_range(255)), 1'b0, '0);
                rand_items++;
            end
            if ($urandom_range(3) == 0)
                drain_digests();
            send_item(1'b1, 8'($urandom_range(255)), 1'b0, '0);
            rand_items++;
        end

        msg_ch.valid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
